[rtl/core/kple_pkg.sv]
// Package: codes, item types and reset constants of the keypad line editor.
package kple_pkg;

  // Line buffer depth default (one slot stays unused, so it holds DEPTH-1 characters)
  localparam int unsigned BUF_DEPTH_DEF = 64;

  // Reset values of the pattern registers ("5599" and "9955")
  localparam logic [31:0] ON_PATTERN_RST  = 32'h3535_3939;
  localparam logic [31:0] OFF_PATTERN_RST = 32'h3939_3535;

  // Special keys
  localparam logic [7:0] KEY_NONE = 8'h00;
  localparam logic [7:0] KEY_HASH = 8'h23;
  localparam logic [7:0] KEY_STAR = 8'h2A;

  // Number of characters compared against a pattern
  localparam int unsigned TAIL_LEN = 4;

  typedef enum logic {
    OP_KEY   = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ECHO_NONE   = 2'd0,
    ECHO_APPEND = 2'd1,
    ECHO_LINE   = 2'd2,
    ECHO_ERASE  = 2'd3
  } echo_action_t;

  typedef enum logic [1:0] {
    LED_NONE = 2'd0,
    LED_ON   = 2'd1,
    LED_OFF  = 2'd2
  } led_action_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ON_PATTERN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_PATTERN = 2'd1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] key_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  echo_action;
    logic [7:0]  echoed_key;
    logic [1:0]  led_action;
    logic [5:0]  buffer_length;
    logic [31:0] line_count;
  } out_item_t;

endpackage

[rtl/core/kple_if.sv]
// Interfaces: input, result and configuration channels of the keypad line editor.
interface kple_in_if
  import kple_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface kple_out_if
  import kple_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface kple_cfg_if
  import kple_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

[rtl/core/keypad_line_editor_pattern_detect_top.sv]
// Top level: keypad line editor with four-character pattern detection.
//
//   channel  | dir | payload                                               | handshake
//   in_ch    | in  | opcode, key_code                                      | valid/ready
//   out_ch   | out | echo_action, echoed_key, led_action, buffer_length,   | valid/ready
//            |     | line_count                                            |
//   cfg_ch   | in  | index, wdata (0 on_pattern, 1 off_pattern)            | valid/ready
//
// One item per cycle unless the output stalls; its result is registered on acceptance.
// State update and pattern compare are combinational; the last four characters are kept
// in a tail register, and one line store read per cycle prefetches the character below them.
// A stalled result holds; in_ch stays ready while the output register is empty or draining.
// rst_n (synchronous) clears the fill, previous key, line count and valid, reloads patterns.
// The line store has no reset and needs no clearing pass; cfg_ch is always ready.
module keypad_line_editor_pattern_detect_top
  import kple_pkg::*;
#(
  parameter int unsigned BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  kple_in_if.sink     in_ch,
  kple_out_if.source  out_ch,
  kple_cfg_if.sink    cfg_ch
);

  localparam int unsigned FW = $clog2(BUF_DEPTH);
  localparam logic [FW-1:0] FILL_MAX  = FW'(BUF_DEPTH - 1);
  localparam logic [FW-1:0] TAIL_MIN  = FW'(TAIL_LEN);
  localparam logic [FW-1:0] BELOW_OFS = FW'(TAIL_LEN + 1);

  // Configuration registers
  logic [31:0] on_pattern_r;
  logic [31:0] off_pattern_r;

  // Editor state
  logic [FW-1:0] fill_r, fill_nxt;
  logic [7:0]    prev_r, prev_nxt;
  logic [31:0]   lines_r, lines_nxt;
  logic [31:0]   tail_r, tail_nxt;     // last four characters, oldest in top byte
  logic [7:0]    below_r;              // character just below the tail

  // Line store
  logic [7:0]    line_mem [BUF_DEPTH];
  logic          mem_we;
  logic [FW-1:0] rd_addr;

  // Output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  out_item_t res_nxt;

  logic          in_fire;
  logic          chk;
  logic [FW+5:0] len_ext;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // Edit step for one item
  always_comb begin
    fill_nxt  = fill_r;
    prev_nxt  = prev_r;
    lines_nxt = lines_r;
    tail_nxt  = tail_r;
    mem_we    = 1'b0;
    chk       = 1'b0;
    res_nxt.echo_action = ECHO_NONE;
    res_nxt.echoed_key  = KEY_NONE;
    res_nxt.led_action  = LED_NONE;
    if (in_fire) begin
      if (in_ch.data.opcode == OP_CLEAR) begin
        fill_nxt = '0;
        prev_nxt = KEY_NONE;
      end else if (in_ch.data.key_code != KEY_NONE) begin
        if (in_ch.data.key_code == KEY_HASH) begin
          if (prev_r == KEY_HASH) begin
            fill_nxt  = '0;
            lines_nxt = lines_r + 32'd1;
            prev_nxt  = KEY_NONE;
            res_nxt.echo_action = ECHO_LINE;
          end else begin
            prev_nxt = KEY_HASH;
          end
        end else if (in_ch.data.key_code == KEY_STAR) begin
          if (prev_r == KEY_STAR) begin
            if (fill_r != '0) begin
              fill_nxt = fill_r - FW'(1);
              tail_nxt = {below_r, tail_r[31:8]};
              res_nxt.echo_action = ECHO_ERASE;
            end
          end else begin
            prev_nxt = KEY_STAR;
          end
        end else begin
          prev_nxt = in_ch.data.key_code;
          chk      = 1'b1;
          if (fill_r < FILL_MAX) begin
            mem_we   = 1'b1;
            fill_nxt = fill_r + FW'(1);
            tail_nxt = {tail_r[23:0], in_ch.data.key_code};
            res_nxt.echo_action = ECHO_APPEND;
            res_nxt.echoed_key  = in_ch.data.key_code;
          end
        end
      end
    end
    // Pattern compare on the updated tail; on pattern wins a tie
    if (chk && (fill_nxt >= TAIL_MIN)) begin
      if (tail_nxt == on_pattern_r) begin
        res_nxt.led_action = LED_ON;
      end else if (tail_nxt == off_pattern_r) begin
        res_nxt.led_action = LED_OFF;
      end
    end
    len_ext = {6'd0, fill_nxt};
    res_nxt.buffer_length = len_ext[5:0];
    res_nxt.line_count    = lines_nxt;
  end

  // Prefetch address: the slot below the tail for the next fill level
  always_comb begin
    if (fill_nxt >= BELOW_OFS) begin
      rd_addr = fill_nxt - BELOW_OFS;
    end else begin
      rd_addr = '0;
    end
  end

  assign out_valid_nxt = in_fire || (out_valid_r && !out_ch.ready);

  // Line store: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[fill_r] <= in_ch.data.key_code;
    end
    below_r <= line_mem[rd_addr];
  end

  // Tail and result payload
  always_ff @(posedge clk) begin
    tail_r <= tail_nxt;
    if (in_fire) begin
      out_data_r <= res_nxt;
    end
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r        <= '0;
      prev_r        <= KEY_NONE;
      lines_r       <= '0;
      out_valid_r   <= 1'b0;
      on_pattern_r  <= ON_PATTERN_RST;
      off_pattern_r <= OFF_PATTERN_RST;
    end else begin
      fill_r      <= fill_nxt;
      prev_r      <= prev_nxt;
      lines_r     <= lines_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_ON_PATTERN) begin
          on_pattern_r <= cfg_ch.wdata;
        end else if (cfg_ch.index == REG_OFF_PATTERN) begin
          off_pattern_r <= cfg_ch.wdata;
        end
      end
    end
  end

  // Fill level never exceeds the usable buffer depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_MAX)
    else $error("fill level beyond buffer capacity");

  // A line end empties the buffer and bumps the line count
  a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res_nxt.echo_action == ECHO_LINE)
      |=> (fill_r == '0) && (lines_r == $past(lines_r) + 32'd1))
    else $error("line end did not update state");

  // Without an accepted item the editor state holds
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(fill_r) && $stable(lines_r) && $stable(prev_r))
    else $error("state changed without an item");

  // Appended characters are never the control keys
  a_append_key: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res_nxt.echo_action == ECHO_APPEND)
      |-> (res_nxt.echoed_key != KEY_HASH) && (res_nxt.echoed_key != KEY_STAR)
          && (res_nxt.echoed_key != KEY_NONE))
    else $error("control key appended to line");

endmodule

[tb/tb_top.sv]
// Testbench for the keypad line editor: line editing, pattern hits and channel stalls.
module tb_top
  import kple_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = BUF_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 200_000;

  logic clk = 1'b0;
  logic rst_n;

  kple_in_if  in_ch ();
  kple_out_if out_ch ();
  kple_cfg_if cfg_ch ();

  keypad_line_editor_pattern_detect_top #(
    .BUF_DEPTH (DEPTH)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Editor state as the block should hold it
  logic [7:0]  line_buf [DEPTH];
  int unsigned fill_cnt;
  logic [7:0]  last_key;
  logic [31:0] lines_ended;
  logic [31:0] on_pat;
  logic [31:0] off_pat;

  out_item_t expected_results [$];

  // Run bookkeeping
  int unsigned errors;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned led_on_hits;
  int unsigned led_off_hits;
  int unsigned erase_hits;
  int unsigned line_hits;
  int unsigned cycle_cnt;

  // Idling controls
  bit idle_on;
  bit stall_on;
  int unsigned hold_request;

  // Apply one item to the editor state and return the result it should give
  function automatic out_item_t edit_line(input in_item_t it);
    out_item_t   r;
    logic [31:0] tail;
    r = '0;
    if (it.opcode == OP_CLEAR) begin
      fill_cnt = 0;
      last_key = KEY_NONE;
    end else if (it.key_code != KEY_NONE) begin
      if (it.key_code == KEY_HASH) begin
        if (last_key == KEY_HASH) begin
          fill_cnt      = 0;
          lines_ended   = lines_ended + 32'd1;
          last_key      = KEY_NONE;
          r.echo_action = ECHO_LINE;
        end else begin
          last_key = KEY_HASH;
        end
      end else if (it.key_code == KEY_STAR) begin
        if (last_key == KEY_STAR) begin
          if (fill_cnt > 0) begin
            fill_cnt      = fill_cnt - 1;
            r.echo_action = ECHO_ERASE;
          end
        end else begin
          last_key = KEY_STAR;
        end
      end else begin
        last_key = it.key_code;
        // one slot stays free, so a full line drops the key
        if (fill_cnt + 1 < DEPTH) begin
          line_buf[fill_cnt] = it.key_code;
          fill_cnt           = fill_cnt + 1;
          r.echo_action      = ECHO_APPEND;
          r.echoed_key       = it.key_code;
        end
        // pattern check runs whether or not the key was stored
        if (fill_cnt >= TAIL_LEN) begin
          tail = {line_buf[fill_cnt-4], line_buf[fill_cnt-3],
                  line_buf[fill_cnt-2], line_buf[fill_cnt-1]};
          if (tail == on_pat)
            r.led_action = LED_ON;
          else if (tail == off_pat)
            r.led_action = LED_OFF;
        end
      end
    end
    r.buffer_length = fill_cnt[5:0];
    r.line_count    = lines_ended;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
    end
  endtask

  // Record accepted items and check accepted results, both at the same edge
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(edit_line(in_ch.data));
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_results.size() == 0) begin
          errors++;
          $error("result item with no item pending (line_count %0d)", got.line_count);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (want.led_action == LED_ON)       led_on_hits++;
          if (want.led_action == LED_OFF)      led_off_hits++;
          if (want.echo_action == ECHO_ERASE)  erase_hits++;
          if (want.echo_action == ECHO_LINE)   line_hits++;
          check_field("echo_action",   32'(want.echo_action),   32'(got.echo_action));
          check_field("echoed_key",    32'(want.echoed_key),    32'(got.echoed_key));
          check_field("led_action",    32'(want.led_action),    32'(got.led_action));
          check_field("buffer_length", 32'(want.buffer_length), 32'(got.buffer_length));
          check_field("line_count",    want.line_count,         got.line_count);
        end
      end
    end
  end

  // Result side: random stall bursts and requested long hold-offs
  initial begin
    int unsigned n;
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        n            = hold_request;
        hold_request = 0;
        out_ch.ready <= 1'b0;
        while (n != 0) begin
          @(posedge clk);
          n--;
        end
        out_ch.ready <= 1'b1;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("keypad_line_editor_pattern_detect_top verification failed");
    $finish;
  end

  // Send one item, with an optional idle burst first
  task automatic send_item(input opcode_t op, input logic [7:0] key);
    in_item_t it;
    it.opcode   = op;
    it.key_code = key;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Four keys, oldest in the top byte
  task automatic send_word(input logic [31:0] w);
    int i;
    for (i = 3; i >= 0; i--)
      send_item(OP_KEY, w[8*i +: 8]);
  endtask

  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Both pattern registers, written back to back while the block is idle
  task automatic set_patterns(input logic [31:0] on_val, input logic [31:0] off_val);
    wait_results_drained();
    repeat (2) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_ON_PATTERN;
    cfg_ch.wdata <= on_val;
    do @(posedge clk); while (!cfg_ch.ready);
    on_pat = on_val;
    cfg_ch.index <= REG_OFF_PATTERN;
    cfg_ch.wdata <= off_val;
    do @(posedge clk); while (!cfg_ch.ready);
    off_pat = off_val;
    cfg_ch.valid <= 1'b0;
  endtask

  // Any key that gets stored: not no-key, not '#', not '*'
  function automatic logic [7:0] plain_key();
    logic [7:0] k;
    do k = 8'($urandom_range(1, 255)); while (k == KEY_HASH || k == KEY_STAR);
    return k;
  endfunction

  // Four characters from a small alphabet so random typing hits them
  function automatic logic [31:0] rand_pattern();
    int i;
    int r;
    logic [31:0] p;
    for (i = 0; i < 4; i++) begin
      r = $urandom_range(0, 13);
      p[8*i +: 8] = (r < 10) ? 8'(8'h30 + r) : 8'(8'h41 + (r - 10));
    end
    return p;
  endfunction

  // Random key weighted toward pattern characters and edit keys
  function automatic logic [7:0] pick_key();
    int sel;
    logic [31:0] pat;
    sel = $urandom_range(0, 99);
    pat = $urandom_range(0, 1) ? on_pat : off_pat;
    if (sel < 35)      return pat[8*$urandom_range(0, 3) +: 8];
    else if (sel < 50) return KEY_STAR;
    else if (sel < 60) return KEY_HASH;
    else if (sel < 70) return 8'(8'h30 + $urandom_range(0, 9));
    else if (sel < 74) return KEY_NONE;
    else               return 8'($urandom_range(0, 255));
  endfunction

  // Directed: every operation and echo kind under the reset patterns
  task automatic test_reset_defaults();
    send_item(OP_KEY, KEY_NONE);
    send_item(OP_CLEAR, 8'hFF);
    send_word(ON_PATTERN_RST);           // "5599" -> led on
    send_item(OP_KEY, 8'h35);
    send_item(OP_KEY, 8'h35);            // tail "9955" -> led off
    send_item(OP_KEY, KEY_STAR);
    send_item(OP_KEY, KEY_STAR);         // erase
    send_item(OP_KEY, KEY_STAR);         // erase again
    send_item(OP_KEY, KEY_HASH);
    send_item(OP_KEY, KEY_HASH);         // line end
    send_item(OP_KEY, KEY_STAR);
    send_item(OP_KEY, KEY_STAR);         // erase on empty line
    send_item(OP_KEY, 8'h80);
    send_item(OP_KEY, 8'h01);
    send_item(OP_KEY, 8'hFF);
    send_item(OP_KEY, 8'h7F);
    send_item(OP_KEY, KEY_HASH);
    send_item(OP_KEY, 8'h58);            // breaks the '#' pair
    send_item(OP_KEY, KEY_HASH);
    send_item(OP_CLEAR, 8'h00);          // clear forgets the pending '#'
    send_item(OP_KEY, KEY_HASH);
  endtask

  // Extreme and equal pattern values
  task automatic test_config_extremes();
    set_patterns(32'hFFFF_FFFF, 32'h0000_0000);
    send_item(OP_CLEAR, 8'h00);
    repeat (5) send_item(OP_KEY, 8'hFF);
    set_patterns(32'h4142_4344, 32'h4142_4344);   // equal: on wins
    send_item(OP_CLEAR, 8'h00);
    send_word(32'h4142_4344);
    set_patterns(32'h0101_0101, 32'hFEFE_FEFE);
    repeat (4) send_item(OP_KEY, 8'h01);
    repeat (4) send_item(OP_KEY, 8'hFE);
  endtask

  // Mostly well-formed edit sequences with random content, some noise
  task automatic test_random_editing(input int unsigned n_items);
    int unsigned stop_at;
    int kind;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        repeat ($urandom_range(0, 3)) send_item(OP_KEY, pick_key());
        send_word($urandom_range(0, 1) ? on_pat : off_pat);
      end else if (kind < 55) begin
        repeat ($urandom_range(2, 5)) send_item(OP_KEY, KEY_STAR);
      end else if (kind < 65) begin
        send_item(OP_KEY, KEY_HASH);
        send_item(OP_KEY, KEY_HASH);
      end else if (kind < 70) begin
        send_item(OP_CLEAR, 8'($urandom_range(0, 255)));
      end else begin
        send_item(OP_KEY, pick_key());
      end
    end
  endtask

  // Fill the line so it ends in a pattern, then keep typing into a full line
  task automatic test_buffer_overflow();
    int pass;
    set_patterns(rand_pattern(), rand_pattern());
    for (pass = 0; pass < 2; pass++) begin
      send_item(OP_CLEAR, 8'($urandom_range(0, 255)));
      repeat (DEPTH - 5) send_item(OP_KEY, plain_key());
      send_word(pass == 0 ? on_pat : off_pat);
      repeat (5) send_item(OP_KEY, plain_key());    // dropped, tail still matches
      repeat (3) send_item(OP_KEY, KEY_STAR);
      send_item(OP_KEY, plain_key());
    end
  endtask

  // Long result hold-off while items keep coming
  task automatic test_backpressure();
    hold_request = 80;
    repeat (30) send_item(OP_KEY, pick_key());
  endtask

  // Sender stops until every result is back, then resumes
  task automatic test_drain_pause();
    test_random_editing(40);
    wait_results_drained();
    test_random_editing(40);
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.data    <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= REG_ON_PATTERN;
    cfg_ch.wdata  <= '0;
    fill_cnt      = 0;
    last_key      = KEY_NONE;
    lines_ended   = '0;
    on_pat        = ON_PATTERN_RST;
    off_pat       = OFF_PATTERN_RST;
    errors        = 0;
    items_sent    = 0;
    results_checked = 0;
    led_on_hits   = 0;
    led_off_hits  = 0;
    erase_hits    = 0;
    line_hits     = 0;
    hold_request  = 0;
    idle_on       = 1'b1;
    stall_on      = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_config_extremes();
    set_patterns(ON_PATTERN_RST, OFF_PATTERN_RST);
    test_random_editing(150);
    set_patterns(rand_pattern(), rand_pattern());
    test_random_editing(150);
    test_buffer_overflow();
    test_backpressure();
    test_drain_pause();
    set_patterns($urandom, $urandom);
    test_random_editing(100);

    // last stretch at full rate on both sides
    set_patterns(rand_pattern(), rand_pattern());
    idle_on  = 1'b0;
    stall_on = 1'b0;
    test_random_editing(100);

    wait_results_drained();
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      errors++;
      $error("%0d expected results never arrived", expected_results.size());
    end

    $display("Run: %0d items sent, %0d results checked, %0d lines ended, %0d erases",
             items_sent, results_checked, line_hits, erase_hits);
    $display("Patterns: %0d on hits, %0d off hits, full line, stalls and hold-off covered",
             led_on_hits, led_off_hits);
    if (errors == 0)
      $display("keypad_line_editor_pattern_detect_top verification clean");
    else
      $display("keypad_line_editor_pattern_detect_top verification failed");
    $finish;
  end

endmodule

[sim.f]
rtl/core/kple_pkg.sv
rtl/core/kple_if.sv
rtl/core/keypad_line_editor_pattern_detect_top.sv
tb/tb_top.sv
